@@ src/gba_pkg.sv @@
// Shared types and constants of the grouped block allocator.
// Used by every module of the block but gba_ram; depends on nothing.
package gba_pkg;

    localparam int DEF_MAX_GROUPS = 16;
    localparam int DEF_MAX_BLOCKS = 65536;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOBLOCK = 2'd1;
    localparam logic [1:0] ST_BADINO  = 2'd2;

    localparam logic [2:0] CFG_FIRST_DATA_BLOCK = 3'd0;
    localparam logic [2:0] CFG_BLOCKS_PER_GROUP = 3'd1;
    localparam logic [2:0] CFG_INODES_PER_GROUP = 3'd2;
    localparam logic [2:0] CFG_TOTAL_BLOCKS     = 3'd3;
    localparam logic [2:0] CFG_GROUP_COUNT      = 3'd4;

    localparam logic [16:0] CURSOR_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  group_index;
        logic [15:0] free_count;
        logic [15:0] away_count;
        logic [15:0] back_count;
        logic [15:0] fixed_block;
        logic [31:0] inode_number;
        logic        priority_req;
    } t_in_item;

    typedef struct packed {
        logic [15:0] block_number;
        logic        own_group;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_LOAD_WR, S_MARK, S_DIV,
        S_OWN, S_EVAL, S_TEST, S_RESULT
    } t_state;

    typedef enum logic [1:0] {PH_OWN, PH_DOWN, PH_UP} t_phase;

    typedef struct packed {
        logic clr;
        logic capture;
        logic load_mul;
        logic load_wr;
        logic mark_wr;
        logic div_step;
        logic own_init;
        logic rd;
        logic inc_cursor;
        logic next_grp;
        logic grant;
        logic res_bad;
        logic res_fail;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] opcode;
        logic       div_last;
        logic       bad_inode;
        logic       skip;
        logic       grp_last;
        logic       fixed;
        logic       next_past;
        logic       out_free;
    } t_dp_status;

endpackage

@@ src/gba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
module gba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ src/gba_ctl.sv @@
// Controller state machine of the grouped block allocator.
// Depends on gba_pkg; drives the datapath by command, reads its status.
module gba_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gba_pkg::t_dp_status i_st,
    output gba_pkg::t_ctl_cmd   o_cmd
);
    gba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gba_pkg::S_CLEAR: if (i_st.clr_last) n_state = gba_pkg::S_IDLE;
            gba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_st.opcode)
                        gba_pkg::OP_LOAD:  n_state = gba_pkg::S_LOAD;
                        gba_pkg::OP_MARK:  n_state = gba_pkg::S_MARK;
                        gba_pkg::OP_ALLOC: n_state = gba_pkg::S_DIV;
                        default:           n_state = gba_pkg::S_IDLE;
                    endcase
                end
            end
            gba_pkg::S_LOAD:    n_state = gba_pkg::S_LOAD_WR;
            gba_pkg::S_LOAD_WR: n_state = gba_pkg::S_IDLE;
            gba_pkg::S_MARK:    n_state = gba_pkg::S_IDLE;
            gba_pkg::S_DIV:     if (i_st.div_last) n_state = gba_pkg::S_OWN;
            gba_pkg::S_OWN: begin
                n_state = i_st.bad_inode ? gba_pkg::S_RESULT : gba_pkg::S_EVAL;
            end
            gba_pkg::S_EVAL: begin
                if (!i_st.skip) begin
                    n_state = gba_pkg::S_TEST;
                end else if (i_st.grp_last) begin
                    n_state = gba_pkg::S_RESULT;
                end
            end
            gba_pkg::S_TEST: begin
                if (!i_st.fixed) begin
                    n_state = gba_pkg::S_RESULT;
                end else if (i_st.next_past && i_st.grp_last) begin
                    n_state = gba_pkg::S_RESULT;
                end else begin
                    n_state = gba_pkg::S_EVAL;
                end
            end
            gba_pkg::S_RESULT: if (i_st.out_free) n_state = gba_pkg::S_IDLE;
            default: n_state = gba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            gba_pkg::S_CLEAR: o_cmd.clr = 1'b1;
            gba_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            gba_pkg::S_LOAD:    o_cmd.load_mul = 1'b1;
            gba_pkg::S_LOAD_WR: o_cmd.load_wr  = 1'b1;
            gba_pkg::S_MARK:    o_cmd.mark_wr  = 1'b1;
            gba_pkg::S_DIV:     o_cmd.div_step = 1'b1;
            gba_pkg::S_OWN: begin
                o_cmd.res_bad  = i_st.bad_inode;
                o_cmd.own_init = !i_st.bad_inode;
            end
            gba_pkg::S_EVAL: begin
                o_cmd.rd       = !i_st.skip;
                o_cmd.next_grp = i_st.skip && !i_st.grp_last;
                o_cmd.res_fail = i_st.skip && i_st.grp_last;
            end
            gba_pkg::S_TEST: begin
                o_cmd.grant      = !i_st.fixed;
                o_cmd.inc_cursor = i_st.fixed;
                o_cmd.next_grp   = i_st.fixed && i_st.next_past && !i_st.grp_last;
                o_cmd.res_fail   = i_st.fixed && i_st.next_past && i_st.grp_last;
            end
            gba_pkg::S_RESULT: o_cmd.out_load = i_st.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule

@@ src/gba_dp.sv @@
// Datapath of the grouped block allocator: configuration, group tables,
// divider, fixed-block map and output register. Depends on gba_pkg, gba_ram.
module gba_dp #(
    parameter int MAX_GROUPS = gba_pkg::DEF_MAX_GROUPS,
    parameter int MAX_BLOCKS = gba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data,
    input  gba_pkg::t_in_item   i_in_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output gba_pkg::t_out_item  o_out_data,
    input  gba_pkg::t_ctl_cmd   i_cmd,
    output gba_pkg::t_dp_status o_st
);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int BLOCK_CAP = (MAX_BLOCKS - 1 < 65535) ? MAX_BLOCKS - 1 : 65535;

    logic        r_cfg_fdb;
    logic [16:0] r_cfg_bpg, r_cfg_ipg, r_cfg_total;
    logic [4:0]  r_cfg_gc;

    gba_pkg::t_in_item r_in;
    logic [15:0]  r_free [MAX_GROUPS];
    logic [16:0]  r_cur  [MAX_GROUPS];
    logic [15:0]  r_end  [MAX_GROUPS];

    logic [AW-1:0] r_clr;
    logic [21:0]   r_first;
    logic [16:0]   r_rem;
    logic [31:0]   r_quo;
    logic [4:0]    r_cnt;
    logic [GW-1:0] r_grp, r_own;
    gba_pkg::t_phase r_phase;
    gba_pkg::t_out_item r_res, r_out;
    logic r_out_valid;

    logic [31:0] ngrp;
    logic [GW:0] up_start;
    logic        ignore_free;
    logic [17:0] div_t;
    logic        div_bit;
    logic        fixed_bit;
    logic        nxt_exists;
    gba_pkg::t_phase nxt_phase;
    logic [GW:0] nxt_grp;
    logic [GW-1:0] ld_g;
    logic        ld_ok, ld_last, ld_neg;
    logic [16:0] ld_sum, ld_diff;
    logic [22:0] ld_endx;
    logic [15:0] ld_free, ld_end;
    logic [16:0] ld_cur;
    logic        mark_ok;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;

    assign ngrp = (32'(r_cfg_gc) < 32'(MAX_GROUPS)) ? 32'(r_cfg_gc) : 32'(MAX_GROUPS);
    assign ignore_free = r_in.priority_req || (r_own == '0);
    assign up_start = ignore_free ? '0 : ((GW+1)'(r_own) + 1'b1);

    // next group in search order
    always_comb begin
        nxt_phase = gba_pkg::PH_UP;
        nxt_grp   = up_start;
        if (r_phase == gba_pkg::PH_OWN && r_own != '0) begin
            nxt_phase = gba_pkg::PH_DOWN;
            nxt_grp   = (GW+1)'(r_own) - 1'b1;
        end else if (r_phase == gba_pkg::PH_DOWN && r_grp != '0) begin
            nxt_phase = gba_pkg::PH_DOWN;
            nxt_grp   = (GW+1)'(r_grp) - 1'b1;
        end else if (r_phase == gba_pkg::PH_UP) begin
            nxt_grp   = (GW+1)'(r_grp) + 1'b1;
        end
        nxt_exists = (nxt_phase == gba_pkg::PH_DOWN) || (32'(nxt_grp) < ngrp);
    end

    assign div_t   = {r_rem, r_quo[31]};
    assign div_bit = div_t >= 18'(r_cfg_ipg);

    // load arithmetic
    always_comb begin
        ld_g    = GW'(r_in.group_index);
        ld_ok   = 32'(r_in.group_index) < ngrp;
        ld_last = 32'(r_in.group_index) == ngrp - 32'd1;
        ld_sum  = 17'(r_in.free_count) + 17'(r_in.away_count);
        ld_diff = ld_sum - 17'(r_in.back_count);
        if (ld_sum > 17'(r_in.back_count)) begin
            ld_free = ld_diff[16] ? 16'hFFFF : ld_diff[15:0];
        end else begin
            ld_free = '0;
        end
        if (ld_last) begin
            ld_neg  = r_cfg_total == '0;
            ld_endx = 23'(r_cfg_total) - 23'd1;
        end else begin
            ld_neg  = (23'(r_first) + 23'(r_cfg_bpg)) == '0;
            ld_endx = 23'(r_first) + 23'(r_cfg_bpg) - 23'd1;
        end
        ld_end = (ld_endx > 23'(BLOCK_CAP)) ? 16'(BLOCK_CAP) : ld_endx[15:0];
        ld_cur = (r_first > 22'(gba_pkg::CURSOR_MAX)) ? gba_pkg::CURSOR_MAX : r_first[16:0];
        if (ld_neg) begin
            ld_end = '0;
            ld_cur = gba_pkg::CURSOR_MAX;
        end
    end

    assign mark_ok   = 32'(r_in.fixed_block) < 32'(MAX_BLOCKS);
    assign ram_we    = i_cmd.clr || (i_cmd.mark_wr && mark_ok);
    assign ram_waddr = i_cmd.clr ? r_clr : AW'(r_in.fixed_block);

    gba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_pin_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(!i_cmd.clr),
        .i_rd_en  (i_cmd.rd),
        .i_rd_addr(AW'(r_cur[r_grp])),
        .o_rd_data(fixed_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fdb   <= 1'b1;
            r_cfg_bpg   <= 17'd8192;
            r_cfg_ipg   <= 17'd2048;
            r_cfg_total <= 17'd65536;
            r_cfg_gc    <= 5'd8;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_free[i] <= '0;
                r_cur[i]  <= '0;
                r_end[i]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gba_pkg::CFG_FIRST_DATA_BLOCK: r_cfg_fdb   <= i_cfg_data[0];
                    gba_pkg::CFG_BLOCKS_PER_GROUP: r_cfg_bpg   <= i_cfg_data;
                    gba_pkg::CFG_INODES_PER_GROUP: r_cfg_ipg   <= i_cfg_data;
                    gba_pkg::CFG_TOTAL_BLOCKS:     r_cfg_total <= i_cfg_data;
                    gba_pkg::CFG_GROUP_COUNT:      r_cfg_gc    <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_wr && ld_ok) begin
                r_free[ld_g] <= ld_free;
                r_cur[ld_g]  <= ld_cur;
                r_end[ld_g]  <= ld_end;
            end
            if (i_cmd.inc_cursor || i_cmd.grant) begin
                r_cur[r_grp] <= r_cur[r_grp] + 1'b1;
            end
            if (i_cmd.grant && r_phase != gba_pkg::PH_OWN && r_free[r_grp] != '0) begin
                r_free[r_grp] <= r_free[r_grp] - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in  <= i_in_data;
            r_rem <= '0;
            r_quo <= i_in_data.inode_number - 32'd1;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_bit ? 17'(div_t - 18'(r_cfg_ipg)) : div_t[16:0];
            r_quo <= {r_quo[30:0], div_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.load_mul) begin
            r_first <= 22'(r_cfg_fdb) + 22'(r_in.group_index) * 22'(r_cfg_bpg);
        end
        if (i_cmd.own_init) begin
            r_own <= GW'(r_quo);
            if (r_in.priority_req) begin
                r_phase <= gba_pkg::PH_UP;
                r_grp   <= '0;
            end else begin
                r_phase <= gba_pkg::PH_OWN;
                r_grp   <= GW'(r_quo);
            end
        end
        if (i_cmd.next_grp) begin
            r_phase <= nxt_phase;
            r_grp   <= GW'(nxt_grp);
        end
        if (i_cmd.grant) begin
            r_res.block_number <= r_cur[r_grp][15:0];
            r_res.own_group    <= (r_phase == gba_pkg::PH_OWN)
                               || (r_phase == gba_pkg::PH_UP && r_grp == r_own);
            r_res.status       <= gba_pkg::ST_OK;
        end
        if (i_cmd.res_bad || i_cmd.res_fail) begin
            r_res.block_number <= '0;
            r_res.own_group    <= 1'b0;
            r_res.status       <= i_cmd.res_bad ? gba_pkg::ST_BADINO : gba_pkg::ST_NOBLOCK;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_st.clr_last  = r_clr == AW'(MAX_BLOCKS - 1);
        o_st.opcode    = i_in_data.opcode;
        o_st.div_last  = r_cnt == 5'd31;
        o_st.bad_inode = (r_in.inode_number == '0) || (r_cfg_ipg == '0) || (r_quo >= ngrp);
        o_st.skip      = (r_cur[r_grp] > 17'(r_end[r_grp]))
                       || (r_free[r_grp] == '0 && (r_phase == gba_pkg::PH_DOWN
                           || (r_phase == gba_pkg::PH_UP && !ignore_free)));
        o_st.grp_last  = !nxt_exists;
        o_st.fixed     = fixed_bit;
        o_st.next_past = r_cur[r_grp] >= 17'(r_end[r_grp]);
        o_st.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ src/grouped_block_allocator_unit.sv @@
// Grouped block allocator, top level: controller plus datapath, one transaction at a time.
// Load passes through the S_LOAD and S_LOAD_WR states, mark through S_MARK. An allocate
// runs the 32-step inode divider, then tests blocks in the fixed-block map and passes
// over groups ruled out by their bounds or free estimate; output stall holds the result.
// Reset is synchronous; afterward the block clears every entry of the fixed map
// and holds input stall during that pass.
module grouped_block_allocator_unit #(
    parameter int MAX_GROUPS = gba_pkg::DEF_MAX_GROUPS,
    parameter int MAX_BLOCKS = gba_pkg::DEF_MAX_BLOCKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gba_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gba_pkg::t_out_item o_out_data
);
    // command and status between sequencer and datapath
    gba_pkg::t_ctl_cmd   cmd;
    gba_pkg::t_dp_status st;

    // sequencer: one transaction at a time, result handed to output register
    gba_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    // datapath: config, group tables, divider, fixed map, output register
    gba_dp #(.MAX_GROUPS(MAX_GROUPS), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_cmd      (cmd),
        .o_st       (st)
    );
endmodule

@@ src/gba_chk.sv @@
// Port-level checker for the grouped block allocator, bound to the top.
// Depends on gba_pkg.
module gba_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input gba_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gba_pkg::t_out_item o_out_data
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // failed transactions carry no block
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != gba_pkg::ST_OK
        |-> o_out_data.block_number == '0 && !o_out_data.own_group)
        else $error("failed result carries a block");

    // load, mark and no-op produce no result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.opcode != gba_pkg::OP_ALLOC
        && !o_out_valid |=> !o_out_valid)
        else $error("result from non-allocate transaction");
endmodule

bind grouped_block_allocator_unit gba_chk u_gba_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

@@ bench/gba_alloc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the grouped block allocator: tracks config writes and accepted
// input transactions, predicts allocate results and compares accepted outputs.
// Depends on gba_pkg for the payload structs, opcodes, status codes and register indexes.
module gba_alloc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_index,
    input  logic [16:0]                 i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  gba_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  gba_pkg::t_out_item          i_out_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    bit          pinned    [65536];
    logic [15:0] free_left [16];
    logic [16:0] cursor    [16];
    logic [15:0] grp_end   [16];
    int unsigned c_fdb, c_bpg, c_ipg, c_total, c_gc;

    gba_pkg::t_out_item expected_grants[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // Skip fixed blocks; give up the group once the cursor passes its end.
    function automatic bit group_ready(input int g);
        if (cursor[g] > {1'b0, grp_end[g]}) return 1'b0;
        while (cursor[g] < 17'h10000 && pinned[cursor[g][15:0]]) begin
            cursor[g]++;
            if (cursor[g] > {1'b0, grp_end[g]}) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_allocation(input gba_pkg::t_in_item it);
        int                 n, g, i, own;
        longint             first, endv, sum;
        bit                 ign, done;
        gba_pkg::t_out_item r;
        n = (c_gc < 16) ? int'(c_gc) : 16;
        case (it.opcode)
            gba_pkg::OP_LOAD: begin
                g = int'(it.group_index);
                if (g < n) begin
                    sum = longint'(it.free_count) + longint'(it.away_count);
                    if (sum > longint'(it.back_count)) begin
                        sum -= longint'(it.back_count);
                        free_left[g] = (sum > 65535) ? 16'hFFFF : sum[15:0];
                    end else begin
                        free_left[g] = '0;
                    end
                    first = longint'(c_fdb) + longint'(g) * longint'(c_bpg);
                    if (g == n - 1) endv = longint'(c_total) - 1;
                    else endv = first + longint'(c_bpg) - 1;
                    if (endv < 0) begin
                        cursor[g]  = gba_pkg::CURSOR_MAX;
                        grp_end[g] = '0;
                    end else begin
                        grp_end[g] = (endv > 65535) ? 16'hFFFF : endv[15:0];
                        cursor[g]  = (first > 131071) ? gba_pkg::CURSOR_MAX : first[16:0];
                    end
                end
            end
            gba_pkg::OP_MARK: pinned[it.fixed_block] = 1'b1;
            gba_pkg::OP_ALLOC: begin
                r = '{block_number: 16'd0, own_group: 1'b0, status: gba_pkg::ST_NOBLOCK};
                done = 1'b0;
                if (it.inode_number == 0 || c_ipg == 0) begin
                    r.status = gba_pkg::ST_BADINO;
                end else if ((longint'(it.inode_number) - 1) / longint'(c_ipg)
                             >= longint'(n)) begin
                    r.status = gba_pkg::ST_BADINO;
                end else begin
                    own = int'((longint'(it.inode_number) - 1) / longint'(c_ipg));
                    if (!it.priority_req) begin
                        // own group first, free estimate untouched
                        if (group_ready(own)) begin
                            r = '{cursor[own][15:0], 1'b1, gba_pkg::ST_OK};
                            cursor[own]++;
                            done = 1'b1;
                        end
                        for (i = own - 1; i >= 0 && !done; i--) begin
                            if (free_left[i] != 0 && group_ready(i)) begin
                                free_left[i]--;
                                r = '{cursor[i][15:0], 1'b0, gba_pkg::ST_OK};
                                cursor[i]++;
                                done = 1'b1;
                            end
                        end
                    end
                    ign = (own == 0) || it.priority_req;
                    for (i = ign ? 0 : own + 1; i < n && !done; i++) begin
                        if ((ign || free_left[i] != 0) && group_ready(i)) begin
                            if (free_left[i] != 0) free_left[i]--;
                            r = '{cursor[i][15:0], (i == own), gba_pkg::ST_OK};
                            cursor[i]++;
                            done = 1'b1;
                        end
                    end
                end
                expected_grants.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        gba_pkg::t_out_item want;
        if (!i_rst_n) begin
            foreach (pinned[b]) pinned[b] = 1'b0;
            foreach (free_left[g]) begin
                free_left[g] = '0;
                cursor[g]    = '0;
                grp_end[g]   = '0;
            end
            c_fdb = 1; c_bpg = 8192; c_ipg = 2048; c_total = 65536; c_gc = 8;
            expected_grants.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    gba_pkg::CFG_FIRST_DATA_BLOCK: c_fdb   = 32'(i_cfg_data[0]);
                    gba_pkg::CFG_BLOCKS_PER_GROUP: c_bpg   = 32'(i_cfg_data);
                    gba_pkg::CFG_INODES_PER_GROUP: c_ipg   = 32'(i_cfg_data);
                    gba_pkg::CFG_TOTAL_BLOCKS:     c_total = 32'(i_cfg_data);
                    gba_pkg::CFG_GROUP_COUNT:      c_gc    = 32'(i_cfg_data[4:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_allocation(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("result with no allocate outstanding");
                end else begin
                    want = expected_grants.pop_front();
                    if (i_out_data.block_number !== want.block_number)
                        report_mismatch($sformatf("block_number got %0d want %0d",
                                        i_out_data.block_number, want.block_number));
                    if (i_out_data.own_group !== want.own_group)
                        report_mismatch($sformatf("own_group got %0b want %0b",
                                        i_out_data.own_group, want.own_group));
                    if (i_out_data.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                        i_out_data.status, want.status));
                end
            end
        end
        o_pending = expected_grants.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

@@ bench/tb_grouped_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, config writes and stimulus.
// Depends on gba_pkg, grouped_block_allocator_unit and gba_alloc_checker.
module tb_grouped_block_allocator_unit;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    gba_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall;
    gba_pkg::t_out_item out_data;
    int                 fail_count;
    int                 pending;

    // idle percentages per side, and the long receiver hold-off request
    int unsigned snd_idle;
    int unsigned rcv_idle;
    bit          hold_long;

    // shadow of the config, used to shape well-formed stimulus
    int unsigned s_ipg, s_total, s_gc;

    grouped_block_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    gba_alloc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stall at each falling edge; on request, hold off
    // for a long stretch so the block backs up and stalls its input.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                out_stall = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
            end
            out_stall = ($urandom_range(99) < rcv_idle);
        end
    end

    // Offer one transaction; valid stays high across back-to-back items.
    task automatic send_item(input gba_pkg::t_in_item it);
        while ($urandom_range(99) < snd_idle) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input int unsigned val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val[16:0];
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    // Drain results, then wait out any load or mark still in progress.
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    function automatic gba_pkg::t_in_item noise_item();
        gba_pkg::t_in_item it;
        logic [127:0]      raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it  = raw[$bits(gba_pkg::t_in_item)-1:0];
        return it;
    endfunction

    function automatic gba_pkg::t_in_item load_item(input int g);
        gba_pkg::t_in_item it;
        it = noise_item();
        it.opcode = gba_pkg::OP_LOAD;
        it.group_index = g[3:0];
        // mostly modest counts so free estimates run out and the search moves on
        if ($urandom_range(3) != 0) begin
            it.free_count = 16'($urandom_range(0, 12));
            it.away_count = 16'($urandom_range(0, 4));
            it.back_count = 16'($urandom_range(0, 6));
        end
        return it;
    endfunction

    function automatic gba_pkg::t_in_item random_item();
        gba_pkg::t_in_item it;
        int unsigned       pick, ngr;
        it   = noise_item();
        ngr  = (s_gc < 16) ? s_gc : 16;
        pick = $urandom_range(99);
        if (pick < 18) begin
            it = load_item(($urandom_range(9) == 0) ? $urandom_range(15)
                                                   : $urandom_range(ngr - 1));
        end else if (pick < 26) begin
            it.opcode = gba_pkg::OP_MARK;
            if ($urandom_range(4) != 0)
                it.fixed_block = 16'($urandom_range(0, s_total - 1));
        end else if (pick < 96) begin
            it.opcode = gba_pkg::OP_ALLOC;
            it.priority_req = ($urandom_range(9) == 0);
            if ($urandom_range(9) == 0)
                it.inode_number = ($urandom_range(1) == 0) ? 32'd0 : $urandom;
            else
                it.inode_number = $urandom_range(1, s_ipg * ngr + s_ipg / 4);
        end else begin
            it.opcode = gba_pkg::OP_NOP;
        end
        return it;
    endfunction

    task automatic run_phase(input int unsigned fdb, input int unsigned bpg,
                             input int unsigned ipg, input int unsigned total,
                             input int unsigned gc, input int count);
        int k;
        wait_quiet();
        write_cfg(gba_pkg::CFG_FIRST_DATA_BLOCK, fdb);
        write_cfg(gba_pkg::CFG_BLOCKS_PER_GROUP, bpg);
        write_cfg(gba_pkg::CFG_INODES_PER_GROUP, ipg);
        write_cfg(gba_pkg::CFG_TOTAL_BLOCKS, total);
        write_cfg(gba_pkg::CFG_GROUP_COUNT, gc);
        s_ipg = ipg; s_total = total; s_gc = gc;
        // set up every group in use before the random mix
        for (k = 0; k < gc; k++) send_item(load_item(k));
        for (k = 0; k < count; k++) send_item(random_item());
    endtask

    task automatic directed_items();
        gba_pkg::t_in_item it;
        int g;
        // never-loaded group zero hands out block zero once
        it = noise_item(); it.opcode = gba_pkg::OP_ALLOC; it.priority_req = 1'b0;
        it.inode_number = 32'd1; send_item(it);
        // saturated and floored estimates, then the other groups
        it = load_item(0); it.free_count = 16'hFFFF; it.away_count = 16'hFFFF;
        it.back_count = 16'h0; send_item(it);
        it = load_item(1); it.free_count = 16'h0; it.away_count = 16'h0;
        it.back_count = 16'hFFFF; send_item(it);
        for (g = 2; g < 8; g++) send_item(load_item(g));
        // load of a group not in use is dropped
        send_item(load_item(15));
        // mark the extremes and the first block of group zero
        it = noise_item(); it.opcode = gba_pkg::OP_MARK; it.fixed_block = 16'd1;
        send_item(it);
        it.fixed_block = 16'hFFFF; send_item(it);
        it.fixed_block = 16'd0; send_item(it);
        // bad inodes: zero, past the last group, all ones
        it = noise_item(); it.opcode = gba_pkg::OP_ALLOC;
        it.inode_number = 32'd0; send_item(it);
        it.inode_number = 32'd16385; send_item(it);
        it.inode_number = 32'hFFFF_FFFF; send_item(it);
        // own group skips the fixed block, then priority and upper groups
        it.priority_req = 1'b0; it.inode_number = 32'd1; send_item(it);
        it.priority_req = 1'b1; it.inode_number = 32'd16384; send_item(it);
        it.priority_req = 1'b0; it.inode_number = 32'd4097; send_item(it);
        it = noise_item(); it.opcode = gba_pkg::OP_NOP; send_item(it);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        hold_long = 1'b0;
        snd_idle  = 20;
        rcv_idle  = 63;
        s_ipg = 2048; s_total = 65536; s_gc = 8;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        // hold off until the fixed-map clearing pass is over
        do @(negedge i_clk); while (in_stall);

        directed_items();

        // sender idles little, receiver a lot
        run_phase(0, 8, 8, 20, 1, 250);
        run_phase(1, 16, 8, 100, 16, 260);
        // swap the idle ratios
        snd_idle = 63; rcv_idle = 20;
        run_phase(1, 65536, 65536, 65536, 16, 250);
        run_phase($urandom_range(1), 8 * $urandom_range(1, 8), $urandom_range(8, 64),
                  $urandom_range(20, 200), $urandom_range(1, 16), 260);
        // no idling; back the block up once with a long hold-off
        snd_idle = 0; rcv_idle = 0;
        hold_long = 1'b1;
        run_phase(0, 24, 16, 150, 6, 260);
        run_phase(1, 8192, 2048, 65536, 8, 250);

        wait_quiet();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
src/gba_pkg.sv
src/gba_ram.sv
src/gba_ctl.sv
src/gba_dp.sv
src/grouped_block_allocator_unit.sv
src/gba_chk.sv
bench/gba_alloc_checker.sv
bench/tb_grouped_block_allocator_unit.sv
